FILE: design/pipe_color_code_expander_core_defines.svh
// assertion macros used by pcce_back
`ifndef PIPE_COLOR_CODE_EXPANDER_CORE_DEFINES_SVH
`define PIPE_COLOR_CODE_EXPANDER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PCCE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PCCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pcce_pkg.sv
package pcce_pkg;

  // queue between parser and expander
  localparam int QUEUE_DEPTH = 4;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ANSI_ENABLED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PARSE_CODES  = 1'b1;

  // longest byte run caused by one input byte
  localparam int MAX_RUN   = 7;
  localparam int RUN_IDX_W = 3;

  // characters
  localparam logic [7:0] CH_PIPE     = 8'h7c;
  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_SEMI     = 8'h3b;
  localparam logic [7:0] CH_LOWER_M  = 8'h6d;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_THREE    = 8'h33;
  localparam logic [7:0] CH_FOUR     = 8'h34;

  // what stands in the middle of a run
  typedef enum logic [2:0] {
    MID_NONE  = 3'd0,
    MID_BYTE  = 3'd1,
    MID_FG    = 3'd2,
    MID_BG    = 3'd3,
    MID_RESET = 3'd4
  } pcce_mid_t;

  // one queued job: held bytes before, middle part, flushed bytes after
  typedef struct packed {
    logic        eot;
    logic [1:0]  pre_cnt;
    logic [3:0]  pre_digit;
    pcce_mid_t   mid;
    logic [7:0]  mid_byte;
    logic        bold;
    logic [2:0]  colour;
    logic [1:0]  post_cnt;
    logic [3:0]  post_digit;
  } pcce_job_t;

  // low three bits of a code to ansi colour number
  function automatic logic [2:0] ansi_colour(input logic [2:0] c);
    logic [2:0] r;
    case (c)
      3'd0:    r = 3'd0;
      3'd1:    r = 3'd4;
      3'd2:    r = 3'd2;
      3'd3:    r = 3'd6;
      3'd4:    r = 3'd1;
      3'd5:    r = 3'd5;
      3'd6:    r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  // decimal digit value to ascii
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return CH_ZERO | {4'h0, d};
  endfunction

endpackage

FILE: design/pcce_front.sv
module pcce_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcce_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte,
  input  logic                            in_end_of_text,
  input  logic                            q_full,
  output logic                            q_push,
  output pcce_pkg::pcce_job_t             q_job
);
  import pcce_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PIPE  = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  phase_t     phase_r, phase_nxt, phase_mid;
  logic [3:0] held_r, held_nxt, held_mid;
  logic       ansi_enabled_r;
  logic       parse_codes_r;
  logic       accept;
  logic       is_pipe, is_digit, take_idle;
  logic [6:0] code;
  pcce_job_t  job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_pipe  = (in_byte == CH_PIPE);
  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  // held * 10 + new digit
  assign code = {held_r, 3'b000} + {2'b00, held_r, 1'b0} + {3'b000, in_byte[3:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ansi_enabled_r <= 1'b1;
      parse_codes_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANSI_ENABLED: ansi_enabled_r <= cfg_wdata[0];
        REG_PARSE_CODES:  parse_codes_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    job       = '0;
    job.mid   = MID_NONE;
    phase_mid = phase_r;
    held_mid  = held_r;
    take_idle = 1'b0;
    if (!parse_codes_r) begin
      unique case (phase_r)
        PH_PIPE:  job.pre_cnt = 2'd1;
        PH_DIGIT: begin
          job.pre_cnt   = 2'd2;
          job.pre_digit = held_r;
        end
        default: ;
      endcase
      job.mid      = MID_BYTE;
      job.mid_byte = in_byte;
      phase_mid    = PH_IDLE;
      held_mid     = 4'd0;
    end else begin
      unique case (phase_r)
        PH_PIPE: begin
          if (is_digit) begin
            phase_mid = PH_DIGIT;
            held_mid  = in_byte[3:0];
          end else begin
            job.pre_cnt = 2'd1;
            take_idle   = 1'b1;
          end
        end
        PH_DIGIT: begin
          held_mid = 4'd0;
          if (is_digit) begin
            phase_mid = PH_IDLE;
            if (ansi_enabled_r) begin
              if (code < 7'd16) begin
                job.mid    = MID_FG;
                job.bold   = code[3];
                job.colour = ansi_colour(code[2:0]);
              end else if (code < 7'd24) begin
                job.mid    = MID_BG;
                job.colour = ansi_colour(code[2:0]);
              end else begin
                job.mid = MID_RESET;
              end
            end
          end else begin
            job.pre_cnt   = 2'd2;
            job.pre_digit = held_r;
            take_idle     = 1'b1;
          end
        end
        default: take_idle = 1'b1;
      endcase
      if (take_idle) begin
        if (is_pipe) begin
          phase_mid = PH_PIPE;
        end else begin
          phase_mid    = PH_IDLE;
          job.mid      = MID_BYTE;
          job.mid_byte = in_byte;
        end
      end
    end

    // end of text flushes whatever is still held
    job.eot = in_end_of_text;
    if (in_end_of_text) begin
      if (phase_mid == PH_PIPE) begin
        job.post_cnt = 2'd1;
      end else if (phase_mid == PH_DIGIT) begin
        job.post_cnt   = 2'd2;
        job.post_digit = held_mid;
      end
      phase_nxt = PH_IDLE;
      held_nxt  = 4'd0;
    end else begin
      phase_nxt = phase_mid;
      held_nxt  = held_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  // a byte that produces nothing is not queued
  assign q_push = accept &&
                  !((job.pre_cnt == 2'd0) && (job.mid == MID_NONE) && (job.post_cnt == 2'd0));
  assign q_job  = job;

endmodule

FILE: design/pcce_fifo.sv
module pcce_fifo #(
  parameter int DEPTH = pcce_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pcce_pkg::pcce_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output pcce_pkg::pcce_job_t head_job
);
  import pcce_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pcce_job_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = entries[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr_r] <= push_job;
  end

endmodule

FILE: design/pcce_back.sv
`include "pipe_color_code_expander_core_defines.svh"

module pcce_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  pcce_pkg::pcce_job_t head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_run_last,
  output logic                out_text_last
);
  import pcce_pkg::*;

  logic [7:0]           seq [MAX_RUN];
  logic [RUN_IDX_W-1:0] seq_len;
  logic [RUN_IDX_W-1:0] pos_r, pos_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r;
  logic                 out_run_last_r, out_text_last_r;
  logic                 load, at_last;

  // lay out the run of the head job
  always_comb begin
    for (int i = 0; i < MAX_RUN; i++) seq[i] = 8'h00;
    seq_len = '0;
    if (head_job.pre_cnt != 2'd0) begin
      seq[seq_len] = CH_PIPE;
      seq_len      = seq_len + 1'b1;
    end
    if (head_job.pre_cnt == 2'd2) begin
      seq[seq_len] = digit_char(head_job.pre_digit);
      seq_len      = seq_len + 1'b1;
    end
    case (head_job.mid) inside
      MID_BYTE: begin
        seq[seq_len] = head_job.mid_byte;
        seq_len      = seq_len + 1'b1;
      end
      MID_FG, MID_BG, MID_RESET: begin
        seq[seq_len] = CH_ESC;
        seq_len      = seq_len + 1'b1;
        seq[seq_len] = CH_LBRACKET;
        seq_len      = seq_len + 1'b1;
        if (head_job.mid == MID_FG) begin
          seq[seq_len] = digit_char({3'b000, head_job.bold});
          seq_len      = seq_len + 1'b1;
          seq[seq_len] = CH_SEMI;
          seq_len      = seq_len + 1'b1;
          seq[seq_len] = CH_THREE;
          seq_len      = seq_len + 1'b1;
          seq[seq_len] = digit_char({1'b0, head_job.colour});
          seq_len      = seq_len + 1'b1;
        end else if (head_job.mid == MID_BG) begin
          seq[seq_len] = CH_FOUR;
          seq_len      = seq_len + 1'b1;
          seq[seq_len] = digit_char({1'b0, head_job.colour});
          seq_len      = seq_len + 1'b1;
        end
        seq[seq_len] = CH_LOWER_M;
        seq_len      = seq_len + 1'b1;
      end
      default: ;
    endcase
    if (head_job.post_cnt != 2'd0) begin
      seq[seq_len] = CH_PIPE;
      seq_len      = seq_len + 1'b1;
    end
    if (head_job.post_cnt == 2'd2) begin
      seq[seq_len] = digit_char(head_job.post_digit);
      seq_len      = seq_len + 1'b1;
    end
  end

  assign load    = head_valid && (!out_valid_r || out_ready);
  assign at_last = (pos_r == seq_len - 1'b1);
  assign pop     = load && at_last;

  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      pos_nxt       = at_last ? '0 : pos_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r      <= seq[pos_r];
      out_run_last_r  <= at_last;
      out_text_last_r <= at_last && head_job.eot;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_run_last  = out_run_last_r;
  assign out_text_last = out_text_last_r;

  `PCCE_ASSERT_IMPL(a_mid_run_has_job, pos_r != '0, head_valid, "run position without job")
  `PCCE_ASSERT_IMPL(a_job_in_range, head_valid, (seq_len != '0) && (pos_r < seq_len),
                    "run position out of range")
  `PCCE_ASSERT_IMPL(a_text_last_ends_run, out_valid_r && out_text_last_r, out_run_last_r,
                    "text end not at run end")
  `PCCE_ASSERT_NEXT(a_pos_steps, load && !at_last, pos_r == $past(pos_r) + 1'b1,
                    "run position skipped")

endmodule

FILE: design/pipe_color_code_expander_core.sv
// pipe colour code expander: rewrites |nn codes into ansi sgr escapes
// a transfer in reaches out through the job queue and then the expander's output register
// throughput: one output byte per cycle while out_ready is high; bytes yielded per item
//   (plain text 1, colour code 3 to 7, dropped code 0), paced by the expander's output register
// input stalls only when the QUEUE_DEPTH-entry job queue is full
// reset: synchronous active-low rst_n; parser idle, queue empty, both config bits set
module pipe_color_code_expander_core #(
  parameter int QUEUE_DEPTH = pcce_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [pcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcce_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // text in
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte,
  input  logic                            in_end_of_text,
  // translated text out
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_run_last,
  output logic                            out_text_last
);
  import pcce_pkg::*;

  // front to queue
  logic      q_push;
  logic      q_full;
  pcce_job_t q_job;
  // queue to back
  logic      head_valid;
  logic      head_pop;
  pcce_job_t head_job;

  // parser: tracks held pipe and digit, classifies each byte into a job
  pcce_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (q_job)
  );

  // short job queue so parsing and expansion stall independently
  pcce_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // expander: walks each job one output byte per transfer
  pcce_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (head_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_text_last (out_text_last)
  );

endmodule

FILE: bench/testbench.sv
module testbench;
  import pcce_pkg::*;

  // kinds of entries in the stimulus queue
  typedef enum logic [0:0] {
    STEP_TEXT = 1'b0,
    STEP_CFG  = 1'b1
  } step_kind_t;

  // parser state of the predictor
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PIPE  = 2'd1,
    PH_DIGIT = 2'd2
  } match_phase_t;

  typedef struct packed {
    step_kind_t            kind;
    logic [7:0]            data;
    logic                  eot;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
  } text_step_t;

  typedef struct packed {
    logic [7:0] b;
    logic       run_last;
    logic       text_last;
  } text_out_t;

  // cycles the block may still be busy after the last byte shows up
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 20;
  // long receiver hold-off, in cycles
  localparam int HOLD_CYCLES   = 100;

  // low three bits of a code to the sgr colour digit
  localparam logic [2:0] SGR_COLOUR [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte        = 8'h00;
  logic       in_end_of_text = 1'b0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_text_last;

  pipe_color_code_expander_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_text_last  (out_text_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // stimulus waiting to be driven, and translated bytes waiting to come out
  text_step_t pending_steps[$];
  text_out_t  expected_text[$];
  logic [7:0] byte_run[$];

  // predictor copy of the registers and the parser state
  logic         pv_ansi  = 1'b1;
  logic         pv_parse = 1'b1;
  match_phase_t pv_phase = PH_IDLE;
  logic [3:0]   pv_digit = 4'd0;

  int  err_cnt = 0;
  int  recv_cnt = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  settle_cnt = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;

  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // append one byte to the run of the current transfer
  task automatic emit_byte(input logic [7:0] b);
    byte_run = {byte_run, b};
  endtask

  // a byte seen while idle: a pipe opens a code, anything else goes straight out
  task automatic take_plain(input logic [7:0] b);
    if (b == CH_PIPE) pv_phase = PH_PIPE;
    else emit_byte(b);
  endtask

  // give back whatever the parser is sitting on
  task automatic flush_held();
    if (pv_phase == PH_PIPE) begin
      emit_byte(CH_PIPE);
    end else if (pv_phase == PH_DIGIT) begin
      emit_byte(CH_PIPE);
      emit_byte(CH_ZERO + {4'h0, pv_digit});
    end
    pv_phase = PH_IDLE;
    pv_digit = 4'd0;
  endtask

  // expected bytes for one accepted text byte
  task automatic expand_byte(input logic [7:0] b, input logic eot);
    int        code;
    text_out_t r;
    byte_run.delete();
    if (!pv_parse) begin
      // parsing off: held bytes first, then the byte as it is
      flush_held();
      emit_byte(b);
    end else begin
      case (pv_phase)
        PH_PIPE: begin
          if (is_digit(b)) begin
            pv_digit = b[3:0];
            pv_phase = PH_DIGIT;
          end else begin
            pv_phase = PH_IDLE;
            emit_byte(CH_PIPE);
            take_plain(b);
          end
        end
        PH_DIGIT: begin
          if (is_digit(b)) begin
            code = int'(pv_digit) * 10 + int'(b - CH_ZERO);
            pv_phase = PH_IDLE;
            pv_digit = 4'd0;
            // ansi bit as it stands at the completing byte
            if (pv_ansi) begin
              emit_byte(CH_ESC);
              emit_byte(CH_LBRACKET);
              if (code < 16) begin
                emit_byte(CH_ZERO + 8'(code / 8));
                emit_byte(CH_SEMI);
                emit_byte(CH_THREE);
                emit_byte(CH_ZERO + {5'h0, SGR_COLOUR[code % 8]});
              end else if (code < 24) begin
                emit_byte(CH_FOUR);
                emit_byte(CH_ZERO + {5'h0, SGR_COLOUR[code % 8]});
              end
              emit_byte(CH_LOWER_M);
            end
          end else begin
            emit_byte(CH_PIPE);
            emit_byte(CH_ZERO + {4'h0, pv_digit});
            pv_phase = PH_IDLE;
            pv_digit = 4'd0;
            take_plain(b);
          end
        end
        default: take_plain(b);
      endcase
    end
    // end of text returns anything still held
    if (eot) flush_held();
    foreach (byte_run[i]) begin
      r.b           = byte_run[i];
      r.run_last    = (i == byte_run.size() - 1);
      r.text_last   = (i == byte_run.size() - 1) && eot;
      expected_text = {expected_text, r};
    end
  endtask

  // driver: one transfer at a time, register writes only once drained
  always @(posedge clk) begin
    logic       took;
    logic       v_next;
    logic       we_next;
    text_step_t s;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      cfg_we     <= 1'b0;
      send_gap   = 0;
      settle_cnt = 0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        expand_byte(in_byte, in_end_of_text);
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = draw_gap(send_burst);
      end
      v_next  = in_valid && !took;
      we_next = 1'b0;
      if (!v_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_steps.size() != 0) begin
          s = pending_steps[0];
          if (s.kind == STEP_TEXT) begin
            void'(pending_steps.pop_front());
            in_byte        <= s.data;
            in_end_of_text <= s.eot;
            v_next         = 1'b1;
            settle_cnt     = 0;
          end else if (expected_text.size() != 0) begin
            // sender pauses until every expected byte is out
            settle_cnt = 0;
          end else if (settle_cnt < SETTLE_CYCLES) begin
            settle_cnt++;
          end else begin
            void'(pending_steps.pop_front());
            we_next   = 1'b1;
            cfg_index <= s.idx;
            cfg_wdata <= s.val;
            if (s.idx == REG_ANSI_ENABLED) pv_ansi = s.val[0];
            else if (s.idx == REG_PARSE_CODES) pv_parse = s.val[0];
            settle_cnt = 0;
          end
        end
      end
      in_valid <= v_next;
      cfg_we   <= we_next;
    end
  end

  // monitor: check every transfer out, throttle out_ready
  always @(posedge clk) begin
    text_out_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        recv_cnt++;
        if (expected_text.size() == 0) begin
          $display("%0t: out_byte expected none actual %h run_last %b text_last %b",
                   $time, out_byte, out_run_last, out_text_last);
          err_cnt++;
        end else begin
          e = expected_text.pop_front();
          if (out_byte !== e.b) begin
            $display("%0t: out_byte expected %h actual %h", $time, e.b, out_byte);
            err_cnt++;
          end
          if (out_run_last !== e.run_last) begin
            $display("%0t: out_run_last expected %b actual %b",
                     $time, e.run_last, out_run_last);
            err_cnt++;
          end
          if (out_text_last !== e.text_last) begin
            $display("%0t: out_text_last expected %b actual %b",
                     $time, e.text_last, out_text_last);
            err_cnt++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_gap = draw_gap(recv_burst);
      end
      // one long hold-off while the sender keeps offering, so the job queue fills
      if (!hold_done && recv_cnt >= 120 && in_valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_text(input logic [7:0] b, input logic eot);
    text_step_t s;
    s = '{kind: STEP_TEXT, data: b, eot: eot, idx: '0, val: '0};
    pending_steps = {pending_steps, s};
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    text_step_t s;
    s = '{kind: STEP_CFG, data: 8'h00, eot: 1'b0, idx: idx, val: val};
    pending_steps = {pending_steps, s};
  endtask

  task automatic add_string(input string str, input logic eot);
    for (int i = 0; i < str.len(); i++)
      add_text(str[i], eot && (i == str.len() - 1));
  endtask

  function automatic logic rand_eot();
    return $urandom_range(0, 19) == 0;
  endfunction

  // random text: mostly well-formed codes, some broken ones and loose bytes
  task automatic add_random_text(input int n);
    int         cnt;
    int         pick;
    logic [7:0] b;
    cnt = 0;
    while (cnt < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        add_text(CH_PIPE, rand_eot());
        // first digit leans toward the colour ranges
        b = ($urandom_range(0, 3) == 0) ? CH_ZERO + 8'($urandom_range(0, 9))
                                         : CH_ZERO + 8'($urandom_range(0, 2));
        add_text(b, rand_eot());
        add_text(CH_ZERO + 8'($urandom_range(0, 9)), rand_eot());
        cnt += 3;
      end else if (pick < 65) begin
        // pipe and digit, then anything
        add_text(CH_PIPE, rand_eot());
        add_text(CH_ZERO + 8'($urandom_range(0, 9)), rand_eot());
        add_text(8'($urandom_range(0, 255)), rand_eot());
        cnt += 3;
      end else if (pick < 75) begin
        // pipe, then anything
        add_text(CH_PIPE, rand_eot());
        add_text(8'($urandom_range(0, 255)), rand_eot());
        cnt += 2;
      end else begin
        add_text(8'($urandom_range(0, 255)), rand_eot());
        cnt += 1;
      end
    end
  endtask

  // stop the run if it hangs
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [1:0] phase_cfg [6];
    phase_cfg = '{2'b11, 2'b01, 2'b10, 2'b00, 2'b11, 2'b01};

    // directed: code extremes and both colour ranges
    add_string("|00", 1'b0);
    add_string("|15", 1'b0);
    add_string("|23", 1'b0);
    add_string("|99", 1'b0);
    // pipe not followed by a digit, pipe and digit then a letter, two pipes
    add_string("|x", 1'b0);
    add_string("|5z", 1'b0);
    add_string("||", 1'b0);
    // zero byte and all-ones byte pass through
    add_text(8'h00, 1'b0);
    add_text(8'hff, 1'b0);
    // end of text while holding a pipe, then a pipe and a digit
    add_text(CH_PIPE, 1'b1);
    add_string("|4", 1'b1);
    // ansi turned off in the middle of a code: dropped at the completing byte
    add_text(CH_PIPE, 1'b0);
    add_cfg(REG_ANSI_ENABLED, 1'b0);
    add_string("12", 1'b0);
    // dropped code carrying end of text: nothing comes out
    add_string("|07", 1'b1);
    add_cfg(REG_ANSI_ENABLED, 1'b1);
    // parsing turned off while a pipe and digit are held
    add_string("|3", 1'b0);
    add_cfg(REG_PARSE_CODES, 1'b0);
    add_text("a", 1'b0);
    add_string("|05", 1'b1);
    add_cfg(REG_PARSE_CODES, 1'b1);

    // random phases over the register settings
    foreach (phase_cfg[p]) begin
      add_cfg(REG_ANSI_ENABLED, phase_cfg[p][1]);
      add_cfg(REG_PARSE_CODES, phase_cfg[p][0]);
      add_random_text(72);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_steps.size() != 0 || in_valid || expected_text.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0 && expected_text.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/pcce_pkg.sv
design/pcce_front.sv
design/pcce_fifo.sv
design/pcce_back.sv
design/pipe_color_code_expander_core.sv
bench/testbench.sv
